FILE: hw/rtl/llcp_pkg.sv
// Package for the LLCP frame header and parameter parser.
// Holds result and status types, protocol codes and the TLV length table.
// No dependencies; the parser, queue, top level and testbench use it by scoped names.
package llcp_pkg;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PARAM  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT_HDR   = 3'd1,
		ST_MISSING_SEQ = 3'd2,
		ST_BAD_TYPE    = 3'd3,
		ST_BAD_LEN     = 3'd4,
		ST_TRUNCATED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		HP_ADAPTER = 3'd0,
		HP_DIR     = 3'd1,
		HP_SAP_HI  = 3'd2,
		HP_SAP_LO  = 3'd3,
		HP_SEQ     = 3'd4,
		HP_PAYLOAD = 3'd5
	} hpos_t;

	localparam logic [3:0] PDU_PAX     = 4'd1;
	localparam logic [3:0] PDU_CONNECT = 4'd4;
	localparam logic [3:0] PDU_CC      = 4'd6;
	localparam logic [3:0] PDU_SNL     = 4'd9;
	localparam logic [3:0] PDU_SEQ_MIN = 4'd12;

	localparam logic [3:0] TLV_NONE    = 4'd0;
	localparam logic [3:0] TLV_VERSION = 4'd1;
	localparam logic [3:0] TLV_MIUX    = 4'd2;
	localparam logic [3:0] TLV_WKS     = 4'd3;
	localparam logic [3:0] TLV_LTO     = 4'd4;
	localparam logic [3:0] TLV_RW      = 4'd5;
	localparam logic [3:0] TLV_SN      = 4'd6;
	localparam logic [3:0] TLV_OPT     = 4'd7;
	localparam logic [3:0] TLV_SDREQ   = 4'd8;
	localparam logic [3:0] TLV_SDRES   = 4'd9;
	localparam logic [7:0] TLV_MAX     = 8'd9;

	localparam logic [1:0] FIXED_LEN [16] = '{
		2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1,
		2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
	};

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  adapter;
		logic        dir_tx;
		logic [5:0]  own_sap;
		logic [5:0]  peer_sap;
		logic [3:0]  pdu_type;
		logic [3:0]  seq_ns;
		logic [3:0]  seq_nr;
		logic [3:0]  param_kind;
		logic [15:0] param_value;
		logic [7:0]  param_tid;
		status_t     status;
	} res_t;

	typedef struct packed {
		logic hv;
		logic sv;
		res_t hres;
		res_t sres;
	} push_t;

endpackage

FILE: hw/rtl/llcp_ifs.sv
// Handshake channel interfaces for the LLCP parser: frame bytes in, results out.
// Depends on nothing; payload fields are plain vectors.
interface llcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface llcp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  adapter;
	logic        dir_tx;
	logic [5:0]  own_sap;
	logic [5:0]  peer_sap;
	logic [3:0]  pdu_type;
	logic [3:0]  seq_ns;
	logic [3:0]  seq_nr;
	logic [3:0]  param_kind;
	logic [15:0] param_value;
	logic [7:0]  param_tid;
	logic [2:0]  status;

	modport source (output valid, output kind, output adapter, output dir_tx,
		output own_sap, output peer_sap, output pdu_type, output seq_ns,
		output seq_nr, output param_kind, output param_value, output param_tid,
		output status, input ready);
	modport sink (input valid, input kind, input adapter, input dir_tx,
		input own_sap, input peer_sap, input pdu_type, input seq_ns,
		input seq_nr, input param_kind, input param_value, input param_tid,
		input status, output ready);
endinterface

FILE: hw/rtl/llcp_parser.sv
// Per-byte frame parser: header fields, TLV walk state and result generation.
// Depends on llcp_pkg; produces up to two results per accepted byte.
module llcp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        frame_byte,
	input  logic              frame_end,
	output llcp_pkg::push_t   push
);

	llcp_pkg::hpos_t   hpos_q, n_hpos;
	logic [7:0]        adapter_q, n_adapter;
	logic              dir_q, n_dir;
	logic [7:0]        sap_hi_q, n_sap_hi;
	logic [5:0]        sap_lo_q, n_sap_lo;
	logic [3:0]        ptype_q, n_ptype;
	logic [3:0]        tlv_type_q, n_tlv_type;
	logic [7:0]        tlv_len_q, n_tlv_len;
	logic [8:0]        tlv_cnt_q, n_tlv_cnt;
	logic [15:0]       vacc_q, n_vacc;
	llcp_pkg::status_t err_q, n_err;

	function automatic llcp_pkg::res_t fill_hdr(input logic [7:0] adp, input logic dir,
		input logic [7:0] shi, input logic [5:0] slo, input logic [3:0] pt);
		llcp_pkg::res_t r;
		r = '0;
		r.kind       = llcp_pkg::KIND_HEADER;
		r.adapter    = adp;
		r.dir_tx     = dir;
		r.own_sap    = dir ? slo : shi[7:2];
		r.peer_sap   = dir ? shi[7:2] : slo;
		r.pdu_type   = pt;
		r.status     = llcp_pkg::ST_OK;
		return r;
	endfunction

	function automatic llcp_pkg::res_t fill_param(input llcp_pkg::res_t hdr,
		input logic [3:0] tt, input logic [15:0] acc_v);
		llcp_pkg::res_t r;
		logic [7:0]     b0;
		logic [7:0]     b1;
		r  = hdr;
		b0 = acc_v[15:8];
		b1 = acc_v[7:0];
		r.kind       = llcp_pkg::KIND_PARAM;
		r.param_kind = tt;
		case (tt)
			llcp_pkg::TLV_VERSION: r.param_value = {8'd0, b0};
			llcp_pkg::TLV_MIUX:    r.param_value = {5'd0, b0[2:0], b1};
			llcp_pkg::TLV_WKS:     r.param_value = acc_v;
			llcp_pkg::TLV_LTO:     r.param_value = {8'd0, b0};
			llcp_pkg::TLV_RW:      r.param_value = {12'd0, b0[3:0]};
			llcp_pkg::TLV_OPT:     r.param_value = {14'd0, b0[1:0]};
			llcp_pkg::TLV_SDREQ:   r.param_tid = b0;
			llcp_pkg::TLV_SDRES: begin
				r.param_tid   = b0;
				r.param_value = {10'd0, b1[5:0]};
			end
			default: r.param_value = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		llcp_pkg::res_t hdr;
		logic           walk;
		logic           go;
		logic [8:0]     cnt1;
		logic [1:0]     flen;
		n_hpos     = hpos_q;
		n_adapter  = adapter_q;
		n_dir      = dir_q;
		n_sap_hi   = sap_hi_q;
		n_sap_lo   = sap_lo_q;
		n_ptype    = ptype_q;
		n_tlv_type = tlv_type_q;
		n_tlv_len  = tlv_len_q;
		n_tlv_cnt  = tlv_cnt_q;
		n_vacc     = vacc_q;
		n_err      = err_q;
		push       = '0;
		go         = 1'b0;
		cnt1       = '0;
		flen       = llcp_pkg::FIXED_LEN[tlv_type_q];
		walk       = (err_q == llcp_pkg::ST_OK) &&
			(ptype_q == llcp_pkg::PDU_PAX || ptype_q == llcp_pkg::PDU_CONNECT ||
			ptype_q == llcp_pkg::PDU_CC || ptype_q == llcp_pkg::PDU_SNL);

		case (hpos_q)
			llcp_pkg::HP_ADAPTER: begin
				n_adapter = frame_byte;
				n_hpos    = llcp_pkg::HP_DIR;
			end
			llcp_pkg::HP_DIR: begin
				n_dir  = frame_byte[0];
				n_hpos = llcp_pkg::HP_SAP_HI;
			end
			llcp_pkg::HP_SAP_HI: begin
				n_sap_hi = frame_byte;
				n_hpos   = llcp_pkg::HP_SAP_LO;
			end
			llcp_pkg::HP_SAP_LO: begin
				n_sap_lo = frame_byte[5:0];
				n_ptype  = {sap_hi_q[1:0], frame_byte[7:6]};
				if (n_ptype >= llcp_pkg::PDU_SEQ_MIN) begin
					n_hpos = llcp_pkg::HP_SEQ;
				end else begin
					push.hv = 1'b1;
					n_hpos  = llcp_pkg::HP_PAYLOAD;
				end
			end
			llcp_pkg::HP_SEQ: begin
				push.hv = 1'b1;
				n_hpos  = llcp_pkg::HP_PAYLOAD;
			end
			default: begin
				if (walk) begin
					if (tlv_cnt_q == 9'd0) begin
						n_tlv_type = (frame_byte >= 8'd1 && frame_byte <= llcp_pkg::TLV_MAX) ?
							frame_byte[3:0] : llcp_pkg::TLV_NONE;
						n_tlv_len  = '0;
						n_vacc     = '0;
						n_tlv_cnt  = 9'd1;
					end else if (tlv_cnt_q == 9'd1) begin
						n_tlv_len = frame_byte;
						n_tlv_cnt = 9'd2;
					end else begin
						go = 1'b1;
						if (tlv_cnt_q == 9'd2) begin
							if (tlv_type_q == llcp_pkg::TLV_NONE) begin
								n_err = llcp_pkg::ST_BAD_TYPE;
								go    = 1'b0;
							end else if (flen != 2'd0 && {6'd0, flen} != tlv_len_q) begin
								n_err = llcp_pkg::ST_BAD_LEN;
								go    = 1'b0;
							end else if (tlv_len_q == 8'd0) begin
								push.hv    = 1'b1;
								n_tlv_type = (frame_byte >= 8'd1 &&
									frame_byte <= llcp_pkg::TLV_MAX) ?
									frame_byte[3:0] : llcp_pkg::TLV_NONE;
								n_tlv_len  = '0;
								n_vacc     = '0;
								n_tlv_cnt  = 9'd1;
								go         = 1'b0;
							end
						end
						if (go) begin
							if (tlv_cnt_q == 9'd2) begin
								n_vacc = {frame_byte, 8'd0};
							end else if (tlv_cnt_q == 9'd3) begin
								n_vacc = vacc_q | {8'd0, frame_byte};
							end
							cnt1 = tlv_cnt_q + 9'd1;
							if (cnt1 == 9'd2 + {1'b0, tlv_len_q}) begin
								push.hv    = 1'b1;
								n_tlv_cnt  = '0;
								n_tlv_type = llcp_pkg::TLV_NONE;
								n_tlv_len  = '0;
							end else begin
								n_tlv_cnt = cnt1;
							end
						end
					end
				end
			end
		endcase

		hdr = fill_hdr(n_adapter, n_dir, n_sap_hi, n_sap_lo, n_ptype);
		if (hpos_q == llcp_pkg::HP_PAYLOAD) begin
			push.hres = fill_param(hdr, tlv_type_q, go ? n_vacc : vacc_q);
			if (go) begin
				n_vacc = '0;
				if (n_tlv_cnt != 9'd0) begin
					n_vacc = (tlv_cnt_q == 9'd2) ? {frame_byte, 8'd0} :
						(tlv_cnt_q == 9'd3) ? (vacc_q | {8'd0, frame_byte}) : vacc_q;
				end
			end
		end else begin
			push.hres = hdr;
			if (hpos_q == llcp_pkg::HP_SEQ) begin
				push.hres.seq_ns = frame_byte[7:4];
				push.hres.seq_nr = frame_byte[3:0];
			end
		end

		push.sres      = '0;
		push.sres.kind = llcp_pkg::KIND_STATUS;
		if (n_hpos == llcp_pkg::HP_ADAPTER || n_hpos == llcp_pkg::HP_DIR ||
			n_hpos == llcp_pkg::HP_SAP_HI || n_hpos == llcp_pkg::HP_SAP_LO) begin
			push.sres.status = llcp_pkg::ST_SHORT_HDR;
		end else if (n_hpos == llcp_pkg::HP_SEQ) begin
			push.sres.status = llcp_pkg::ST_MISSING_SEQ;
		end else if (n_err != llcp_pkg::ST_OK) begin
			push.sres.status = n_err;
		end else if (n_tlv_cnt >= 9'd3) begin
			push.sres.status = llcp_pkg::ST_TRUNCATED;
		end else begin
			push.sres.status = llcp_pkg::ST_OK;
		end

		if (frame_end) begin
			push.sv    = 1'b1;
			n_hpos     = llcp_pkg::HP_ADAPTER;
			n_adapter  = '0;
			n_dir      = 1'b0;
			n_sap_hi   = '0;
			n_sap_lo   = '0;
			n_ptype    = '0;
			n_tlv_type = llcp_pkg::TLV_NONE;
			n_tlv_len  = '0;
			n_tlv_cnt  = '0;
			n_vacc     = '0;
			n_err      = llcp_pkg::ST_OK;
		end

		if (!acc) begin
			push.hv = 1'b0;
			push.sv = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q     <= llcp_pkg::HP_ADAPTER;
			adapter_q  <= '0;
			dir_q      <= 1'b0;
			sap_hi_q   <= '0;
			sap_lo_q   <= '0;
			ptype_q    <= '0;
			tlv_type_q <= llcp_pkg::TLV_NONE;
			tlv_len_q  <= '0;
			tlv_cnt_q  <= '0;
			vacc_q     <= '0;
			err_q      <= llcp_pkg::ST_OK;
		end else if (acc) begin
			hpos_q     <= n_hpos;
			adapter_q  <= n_adapter;
			dir_q      <= n_dir;
			sap_hi_q   <= n_sap_hi;
			sap_lo_q   <= n_sap_lo;
			ptype_q    <= n_ptype;
			tlv_type_q <= n_tlv_type;
			tlv_len_q  <= n_tlv_len;
			tlv_cnt_q  <= n_tlv_cnt;
			vacc_q     <= n_vacc;
			err_q      <= n_err;
		end
	end

endmodule

FILE: hw/rtl/llcp_rqueue.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on llcp_pkg; signals on room that two more results fit.
module llcp_rqueue (
	input  logic            clk,
	input  logic            arst_n,
	input  llcp_pkg::push_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output llcp_pkg::res_t  out_res
);

	llcp_pkg::res_t               mem [llcp_pkg::RQ_DEPTH];
	logic [llcp_pkg::RQ_AW-1:0]   wr_q;
	logic [llcp_pkg::RQ_AW-1:0]   rd_q;
	logic [llcp_pkg::RQ_AW:0]     cnt_q;
	logic [1:0]                   n_push;
	logic                         pop;
	logic [llcp_pkg::RQ_AW-1:0]   wr2;

	assign n_push    = {1'b0, push.hv} + {1'b0, push.sv};
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem[rd_q];
	assign room      = (cnt_q <= (llcp_pkg::RQ_AW + 1)'(llcp_pkg::RQ_DEPTH - 2));
	assign wr2       = wr_q + llcp_pkg::RQ_AW'(push.hv);

	always_ff @(posedge clk) begin
		if (push.hv) begin
			mem[wr_q] <= push.hres;
		end
		if (push.sv) begin
			mem[wr2] <= push.sres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + llcp_pkg::RQ_AW'(n_push);
			rd_q  <= rd_q + llcp_pkg::RQ_AW'(pop);
			cnt_q <= cnt_q + (llcp_pkg::RQ_AW + 1)'(n_push) - (llcp_pkg::RQ_AW + 1)'(pop);
		end
	end

endmodule

FILE: hw/rtl/llcp_pdu_header_tlv_parser_top.sv
// Top level of the LLCP frame header and parameter parser.
// Depends on llcp_pkg, llcp_ifs, llcp_parser and llcp_rqueue.
//
// Usage:
// - in_ch carries one frame byte per item; frame_end marks the last byte.
// - out_ch carries result items: a header item after the LLCP header (or
//   after the sequence byte for sequenced PDUs), a parameter item per decoded
//   TLV, and one status item at every frame end.
// - Results: a result enters the result queue as the byte that causes it is
//   taken and is offered on out_ch in order. A byte may cause two results
//   (header or parameter plus frame status); they leave in that order.
// - Input: one byte per cycle while in_ch.ready is high. A four-entry result
//   queue sets the pace: in_ch.ready is high while two entries are free.
// - Receiver stall: results wait in the queue; once it holds more than two,
//   in_ch.ready drops until out_ch takes items again.
// - Reset (arst_n low): parser state returns to the start of a frame and the
//   queue empties; no item is offered until new bytes arrive.
module llcp_pdu_header_tlv_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	llcp_in_if.sink           in_ch,
	llcp_out_if.source        out_ch
);

	llcp_pkg::push_t push;
	llcp_pkg::res_t  res;
	logic            room;
	logic            acc;

	assign in_ch.ready = room;
	assign acc         = in_ch.valid && room;

	llcp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.frame_byte (in_ch.frame_byte),
		.frame_end  (in_ch.frame_end),
		.push       (push)
	);

	llcp_rqueue u_rqueue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	assign out_ch.kind        = res.kind;
	assign out_ch.adapter     = res.adapter;
	assign out_ch.dir_tx      = res.dir_tx;
	assign out_ch.own_sap     = res.own_sap;
	assign out_ch.peer_sap    = res.peer_sap;
	assign out_ch.pdu_type    = res.pdu_type;
	assign out_ch.seq_ns      = res.seq_ns;
	assign out_ch.seq_nr      = res.seq_nr;
	assign out_ch.param_kind  = res.param_kind;
	assign out_ch.param_value = res.param_value;
	assign out_ch.param_tid   = res.param_tid;
	assign out_ch.status      = res.status;

endmodule

FILE: bench/tb.sv
// Testbench for llcp_pdu_header_tlv_parser_top: feeds generated LLCP frames byte by byte,
// predicts header, parameter and frame status items, and checks them on out_ch.
// Depends on llcp_pkg, llcp_ifs and the parser RTL.
`timescale 1ns / 100ps

module tb;

	localparam logic [3:0] FIXED_KINDS [7] = '{
		llcp_pkg::TLV_MIUX, llcp_pkg::TLV_WKS, llcp_pkg::TLV_SDRES, llcp_pkg::TLV_VERSION,
		llcp_pkg::TLV_LTO, llcp_pkg::TLV_RW, llcp_pkg::TLV_OPT
	};
	localparam int HOLDOFF_CYCLES = 150;

	logic clk;
	logic arst_n;

	llcp_in_if  in_ch ();
	llcp_out_if out_ch ();

	llcp_pdu_header_tlv_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// parser state as the predictor sees it
	llcp_pkg::hpos_t   hdr_pos;
	logic [7:0]        hdr_adapter;
	logic              hdr_dir;
	logic [7:0]        sap_hi_byte;
	logic [7:0]        sap_lo_byte;
	logic [3:0]        hdr_pdu;
	logic [3:0]        tlv_kind;
	logic [7:0]        tlv_length;
	int                tlv_seen;
	logic [15:0]       tlv_bytes;
	llcp_pkg::status_t walk_err;

	llcp_pkg::res_t pending_results[$];
	logic [7:0]     frame_buf[$];
	int             mismatches = 0;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             holdoff_req = 0;
	int             bytes_sent;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [1:0] tlv_fixed_len(input logic [3:0] k);
		case (k)
		llcp_pkg::TLV_VERSION, llcp_pkg::TLV_LTO, llcp_pkg::TLV_RW, llcp_pkg::TLV_OPT:
			return 2'd1;
		llcp_pkg::TLV_MIUX, llcp_pkg::TLV_WKS, llcp_pkg::TLV_SDRES: return 2'd2;
		default: return 2'd0;
		endcase
	endfunction

	function automatic bit is_walked(input logic [3:0] pdu);
		return pdu == llcp_pkg::PDU_PAX || pdu == llcp_pkg::PDU_CONNECT ||
			pdu == llcp_pkg::PDU_CC || pdu == llcp_pkg::PDU_SNL;
	endfunction

	function automatic void clear_frame_state();
		hdr_pos     = llcp_pkg::HP_ADAPTER;
		hdr_adapter = '0;
		hdr_dir     = 1'b0;
		sap_hi_byte = '0;
		sap_lo_byte = '0;
		hdr_pdu     = '0;
		tlv_kind    = llcp_pkg::TLV_NONE;
		tlv_length  = '0;
		tlv_seen    = 0;
		tlv_bytes   = '0;
		walk_err    = llcp_pkg::ST_OK;
	endfunction

	function automatic llcp_pkg::res_t header_result();
		llcp_pkg::res_t r;
		logic [5:0] dsap;
		logic [5:0] ssap;
		r = '0;
		dsap = sap_hi_byte[7:2];
		ssap = sap_lo_byte[5:0];
		r.kind       = llcp_pkg::KIND_HEADER;
		r.adapter    = hdr_adapter;
		r.dir_tx     = hdr_dir;
		r.own_sap    = hdr_dir ? ssap : dsap;
		r.peer_sap   = hdr_dir ? dsap : ssap;
		r.pdu_type   = hdr_pdu;
		r.status     = llcp_pkg::ST_OK;
		return r;
	endfunction

	function automatic void push_param();
		llcp_pkg::res_t r;
		logic [7:0] b0;
		logic [7:0] b1;
		r = header_result();
		b0 = tlv_bytes[15:8];
		b1 = tlv_bytes[7:0];
		r.kind       = llcp_pkg::KIND_PARAM;
		r.param_kind = tlv_kind;
		case (tlv_kind)
		llcp_pkg::TLV_VERSION: r.param_value = {8'd0, b0};
		llcp_pkg::TLV_MIUX: r.param_value = {5'd0, b0[2:0], b1};
		llcp_pkg::TLV_WKS: r.param_value = tlv_bytes;
		llcp_pkg::TLV_LTO: r.param_value = {8'd0, b0};
		llcp_pkg::TLV_RW: r.param_value = {12'd0, b0[3:0]};
		llcp_pkg::TLV_OPT: r.param_value = {14'd0, b0[1:0]};
		llcp_pkg::TLV_SDREQ: r.param_tid = b0;
		llcp_pkg::TLV_SDRES: begin
			r.param_tid   = b0;
			r.param_value = {10'd0, b1[5:0]};
		end
		default: ;
		endcase
		pending_results.push_back(r);
	endfunction

	function automatic void start_tlv(input logic [7:0] b);
		tlv_kind   = (b >= 8'd1 && b <= llcp_pkg::TLV_MAX) ? b[3:0] : llcp_pkg::TLV_NONE;
		tlv_length = '0;
		tlv_bytes  = '0;
		tlv_seen   = 1;
	endfunction

	function automatic void walk_tlv_byte(input logic [7:0] b);
		if (tlv_seen == 0) begin
			start_tlv(b);
			return;
		end
		if (tlv_seen == 1) begin
			tlv_length = b;
			tlv_seen   = 2;
			return;
		end
		if (tlv_seen == 2) begin
			if (tlv_kind == llcp_pkg::TLV_NONE) begin
				walk_err = llcp_pkg::ST_BAD_TYPE;
				return;
			end
			if (tlv_fixed_len(tlv_kind) != 0 && tlv_fixed_len(tlv_kind) != tlv_length) begin
				walk_err = llcp_pkg::ST_BAD_LEN;
				return;
			end
			// zero-length item is reported once the next type byte shows up
			if (tlv_length == 0) begin
				push_param();
				start_tlv(b);
				return;
			end
		end
		if (tlv_seen == 2)
			tlv_bytes = {b, 8'd0};
		else if (tlv_seen == 3)
			tlv_bytes[7:0] = b;
		tlv_seen++;
		if (tlv_seen == 2 + int'(tlv_length)) begin
			push_param();
			tlv_seen   = 0;
			tlv_kind   = llcp_pkg::TLV_NONE;
			tlv_length = '0;
			tlv_bytes  = '0;
		end
	endfunction

	function automatic void predict_llcp_byte(input logic [7:0] b, input logic last);
		llcp_pkg::res_t r;
		case (hdr_pos)
		llcp_pkg::HP_ADAPTER: begin
			hdr_adapter = b;
			hdr_pos     = llcp_pkg::HP_DIR;
		end
		llcp_pkg::HP_DIR: begin
			hdr_dir = b[0];
			hdr_pos = llcp_pkg::HP_SAP_HI;
		end
		llcp_pkg::HP_SAP_HI: begin
			sap_hi_byte = b;
			hdr_pos     = llcp_pkg::HP_SAP_LO;
		end
		llcp_pkg::HP_SAP_LO: begin
			sap_lo_byte = b;
			hdr_pdu     = {sap_hi_byte[1:0], b[7:6]};
			if (hdr_pdu >= llcp_pkg::PDU_SEQ_MIN) begin
				hdr_pos = llcp_pkg::HP_SEQ;
			end else begin
				pending_results.push_back(header_result());
				hdr_pos = llcp_pkg::HP_PAYLOAD;
			end
		end
		llcp_pkg::HP_SEQ: begin
			r = header_result();
			r.seq_ns = b[7:4];
			r.seq_nr = b[3:0];
			pending_results.push_back(r);
			hdr_pos = llcp_pkg::HP_PAYLOAD;
		end
		default: begin
			if (walk_err == llcp_pkg::ST_OK && is_walked(hdr_pdu))
				walk_tlv_byte(b);
		end
		endcase
		if (last) begin
			r = '0;
			r.kind = llcp_pkg::KIND_STATUS;
			if (hdr_pos < llcp_pkg::HP_SEQ)
				r.status = llcp_pkg::ST_SHORT_HDR;
			else if (hdr_pos == llcp_pkg::HP_SEQ)
				r.status = llcp_pkg::ST_MISSING_SEQ;
			else if (walk_err != llcp_pkg::ST_OK)
				r.status = walk_err;
			else if (tlv_seen >= 3)
				r.status = llcp_pkg::ST_TRUNCATED;
			else
				r.status = llcp_pkg::ST_OK;
			pending_results.push_back(r);
			clear_frame_state();
		end
	endfunction

	function automatic string res_text(input llcp_pkg::res_t r);
		return $sformatf({"kind=%0d adp=%02h dir=%0d lsap=%02h rsap=%02h pdu=%0d ",
			"ns=%0d nr=%0d pk=%0d pv=%04h tid=%02h st=%0d"},
			r.kind, r.adapter, r.dir_tx, r.own_sap, r.peer_sap, r.pdu_type,
			r.seq_ns, r.seq_nr, r.param_kind, r.param_value, r.param_tid, r.status);
	endfunction

	function automatic bit res_differs(input llcp_pkg::res_t a, input llcp_pkg::res_t b);
		return a.kind !== b.kind || a.adapter !== b.adapter || a.dir_tx !== b.dir_tx ||
			a.own_sap !== b.own_sap || a.peer_sap !== b.peer_sap ||
			a.pdu_type !== b.pdu_type || a.seq_ns !== b.seq_ns ||
			a.seq_nr !== b.seq_nr || a.param_kind !== b.param_kind ||
			a.param_value !== b.param_value || a.param_tid !== b.param_tid ||
			a.status !== b.status;
	endfunction

	function automatic void note_mismatch(input string what, input llcp_pkg::res_t want,
		input llcp_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("tb: %s at %0t", what, $time);
			$display("  expected %s", res_text(want));
			$display("  actual   %s", res_text(got));
		end
	endfunction

	initial begin : result_checker
		llcp_pkg::res_t got;
		llcp_pkg::res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.kind        = llcp_pkg::kind_t'(out_ch.kind);
				got.adapter     = out_ch.adapter;
				got.dir_tx      = out_ch.dir_tx;
				got.own_sap     = out_ch.own_sap;
				got.peer_sap    = out_ch.peer_sap;
				got.pdu_type    = out_ch.pdu_type;
				got.seq_ns      = out_ch.seq_ns;
				got.seq_nr      = out_ch.seq_nr;
				got.param_kind  = out_ch.param_kind;
				got.param_value = out_ch.param_value;
				got.param_tid   = out_ch.param_tid;
				got.status      = llcp_pkg::status_t'(out_ch.status);
				if (pending_results.size() == 0) begin
					note_mismatch("item with nothing pending", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (res_differs(want, got))
						note_mismatch("item mismatch", want, got);
				end
			end
		end
	end

	initial begin : sink_pacing
		int holdoff_left;
		int req_seen;
		holdoff_left = 0;
		req_seen     = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req != req_seen) begin
				req_seen     = holdoff_req;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.frame_byte <= b;
		in_ch.frame_end  <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_llcp_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void put_fixed_header(input logic [7:0] adapter,
		input logic [7:0] dir_byte, input logic [5:0] dsap, input logic [3:0] pdu,
		input logic [5:0] ssap);
		frame_buf.push_back(adapter);
		frame_buf.push_back(dir_byte);
		frame_buf.push_back({dsap, pdu[3:2]});
		frame_buf.push_back({pdu[1:0], ssap});
	endfunction

	function automatic void put_header(input logic [3:0] pdu);
		put_fixed_header(8'($urandom), 8'($urandom), 6'($urandom), pdu, 6'($urandom));
	endfunction

	function automatic void put_good_tlv();
		logic [3:0] k;
		int len;
		k = 4'($urandom_range(1, 9));
		if (k == llcp_pkg::TLV_SN || k == llcp_pkg::TLV_SDREQ)
			len = ($urandom_range(0, 59) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 3);
		else
			len = tlv_fixed_len(k);
		frame_buf.push_back({4'd0, k});
		frame_buf.push_back(8'(len));
		repeat (len) frame_buf.push_back(8'($urandom));
	endfunction

	function automatic logic [3:0] pick_pdu();
		if ($urandom_range(0, 4) == 0)
			return 4'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
		0: return llcp_pkg::PDU_PAX;
		1: return llcp_pkg::PDU_CONNECT;
		2: return llcp_pkg::PDU_CC;
		default: return llcp_pkg::PDU_SNL;
		endcase
	endfunction

	task automatic send_random_frame();
		int shape;
		int fault;
		int len;
		logic [3:0] pdu;
		logic [3:0] k;
		logic [7:0] len_byte;
		frame_buf.delete();
		shape = $urandom_range(0, 99);
		if (shape < 6) begin
			repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
		end else if (shape < 11) begin
			put_header(4'($urandom_range(llcp_pkg::PDU_SEQ_MIN, 15)));
		end else begin
			pdu = pick_pdu();
			put_header(pdu);
			if (pdu >= llcp_pkg::PDU_SEQ_MIN)
				frame_buf.push_back(8'($urandom));
			if (!is_walked(pdu)) begin
				repeat ($urandom_range(0, 6)) frame_buf.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(0, 4)) put_good_tlv();
				fault = $urandom_range(0, 99);
				if (fault < 55) begin
					// well-formed, nothing to add
				end else if (fault < 63) begin
					frame_buf.push_back(
						8'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 255)));
					frame_buf.push_back(8'($urandom));
					repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
				end else if (fault < 71) begin
					k = FIXED_KINDS[$urandom_range(0, 6)];
					len_byte = 8'($urandom);
					if (len_byte == tlv_fixed_len(k))
						len_byte = len_byte + 8'd3;
					frame_buf.push_back({4'd0, k});
					frame_buf.push_back(len_byte);
					repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
				end else if (fault < 80) begin
					// cut off inside the value bytes
					if ($urandom_range(0, 1)) begin
						frame_buf.push_back({4'd0, FIXED_KINDS[$urandom_range(0, 2)]});
						frame_buf.push_back(8'd2);
						frame_buf.push_back(8'($urandom));
					end else begin
						len = $urandom_range(2, 8);
						frame_buf.push_back({4'd0, $urandom_range(0, 1) ?
							llcp_pkg::TLV_SN : llcp_pkg::TLV_SDREQ});
						frame_buf.push_back(8'(len));
						repeat ($urandom_range(1, len - 1)) frame_buf.push_back(8'($urandom));
					end
				end else if (fault < 92) begin
					repeat ($urandom_range(1, 2)) frame_buf.push_back(8'($urandom));
				end
			end
		end
		send_frame();
	endtask

	task automatic run_random_frames(input int target);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < target)
			send_random_frame();
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// one-byte frame: short header
		frame_buf = '{8'hFF};
		send_frame();
		// sequenced type ending before its sequence byte
		frame_buf.delete();
		put_fixed_header(8'h00, 8'h01, 6'h00, llcp_pkg::PDU_SEQ_MIN + 4'd3, 6'h00);
		send_frame();
		// sequenced type with N(S)/N(R), receive direction, all-ones adapter and SAP fields
		frame_buf.delete();
		put_fixed_header(8'hFF, 8'hFE, 6'h3F, llcp_pkg::PDU_SEQ_MIN, 6'h3F);
		frame_buf.push_back(8'hA5);
		send_frame();
		// zero-length SN and SDREQ, full MIUX, then a trailing invalid fragment
		frame_buf.delete();
		put_fixed_header(8'h80, 8'h01, 6'h2A, llcp_pkg::PDU_CONNECT, 6'h15);
		frame_buf.push_back({4'd0, llcp_pkg::TLV_SN});
		frame_buf.push_back(8'h00);
		frame_buf.push_back({4'd0, llcp_pkg::TLV_SDREQ});
		frame_buf.push_back(8'h00);
		frame_buf.push_back({4'd0, llcp_pkg::TLV_MIUX});
		frame_buf.push_back(8'h02);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h40);
		send_frame();
		wait_drain();
	endtask

	task automatic test_streaming();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_frames(200);
		wait_drain();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 79;
		recv_stall_pct = 0;
		run_random_frames(200);
		wait_drain();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 79;
		run_random_frames(200);
		wait_drain();
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		run_random_frames(150);
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// hold the output while bytes keep coming so the queue fills
		holdoff_req++;
		run_random_frames(60);
		wait_drain();
		repeat (3) begin
			send_random_frame();
			wait_drain();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.frame_byte = '0;
		in_ch.frame_end  = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		bytes_sent       = 0;
		clear_frame_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin : run_limit
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/llcp_pkg.sv
hw/rtl/llcp_ifs.sv
hw/rtl/llcp_parser.sv
hw/rtl/llcp_rqueue.sv
hw/rtl/llcp_pdu_header_tlv_parser_top.sv
bench/tb.sv
